[hw/rtl/motor_node_spi_encoder_monitor_assert.svh]
// ----------------------------------------------------------------------------
// motor_node_spi_encoder_monitor_assert.svh
// Assertion macros shared by the motor node monitor modules.
// ----------------------------------------------------------------------------
`ifndef MOTOR_NODE_SPI_ENCODER_MONITOR_ASSERT_SVH
`define MOTOR_NODE_SPI_ENCODER_MONITOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MNSEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor node monitor check failed");

// Next-cycle implication, checked out of reset.
`define MNSEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor node monitor check failed");

`endif

[hw/rtl/mnsem_pkg.sv]
// ----------------------------------------------------------------------------
// mnsem_pkg
// Shared types and constants of the motor node SPI / encoder monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mnsem_pkg;

  // Item kinds, as carried on the input tuser field
  typedef enum logic [1:0] {
    ACT_SPI = 2'd0,
    ACT_ENC = 2'd1,
    ACT_VEL = 2'd2,
    ACT_ADC = 2'd3
  } action_t;

  // Classified request handed from front to back
  typedef struct packed {
    action_t     kind;
    logic [7:0]  byte_val;  // SPI rx byte or ADC sample
    logic        step_up;   // encoder direction
  } cmd_t;

  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [7:0] TX_RESET_BYTE = 8'h13;
  localparam logic [7:0] HEADER_RESET  = 8'h7F;
  localparam logic [2:0] ADC_CH_SIX    = 3'd6;
  localparam logic [2:0] ADC_CH_SEVEN  = 3'd7;

endpackage

`default_nettype wire

[hw/rtl/mnsem_front.sv]
// ----------------------------------------------------------------------------
// mnsem_front
// Accepts input requests and classifies them into queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mnsem_front
  import mnsem_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]           in_tuser,
  output logic                      cmd_valid,
  input  wire logic                 cmd_ready,
  output cmd_t                      cmd
);

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;

  assign in_tready = !cmd_valid_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd_nxt.kind     = action_t'(in_tuser);
    cmd_nxt.byte_val = (action_t'(in_tuser) == ACT_ADC) ? in_tdata[17:10] : in_tdata[7:0];
    // count up when both pins agree
    cmd_nxt.step_up  = ~(in_tdata[8] ^ in_tdata[9]);
    cmd_valid_nxt    = accept || (cmd_valid_r && !cmd_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

[hw/rtl/mnsem_queue.sv]
// ----------------------------------------------------------------------------
// mnsem_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motor_node_spi_encoder_monitor_assert.svh"

module mnsem_queue
  import mnsem_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MNSEM_ASSERT_IMP(a_q_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `MNSEM_ASSERT_NXT(a_q_grow, push && !pop, count_r == $past(count_r) + CNT_W'(1))
  `MNSEM_ASSERT_NXT(a_q_hold, push && pop, count_r == $past(count_r))

endmodule

`default_nettype wire

[hw/rtl/mnsem_back.sv]
// ----------------------------------------------------------------------------
// mnsem_back
// Executes commands: SPI framer, encoder count, velocity latch, ADC readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motor_node_spi_encoder_monitor_assert.svh"

module mnsem_back
  import mnsem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [7:0]            frame_header,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_t                  cmd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data
);

  typedef enum logic [2:0] {
    FR_WAIT_HDR = 3'd0,
    FR_SETPOINT = 3'd1,
    FR_VOLTAGE  = 3'd2,
    FR_PAD0     = 3'd3,
    FR_PAD1     = 3'd4
  } frame_state_t;

  frame_state_t frame_r, frame_nxt;
  logic [15:0]  position_r, position_nxt;
  logic [15:0]  previous_r, previous_nxt;
  logic [15:0]  velocity_r, velocity_nxt;
  logic [7:0]   current_r, current_nxt;
  logic [7:0]   temperature_r, temperature_nxt;
  logic         chan7_r, chan7_nxt;
  logic [7:0]   setpoint_r, setpoint_nxt;
  logic [7:0]   voltage_r, voltage_nxt;
  logic [7:0]   tx_r, tx_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         pop;

  // Take a command whenever the result slot is free or being drained
  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    frame_nxt       = frame_r;
    position_nxt    = position_r;
    previous_nxt    = previous_r;
    velocity_nxt    = velocity_r;
    current_nxt     = current_r;
    temperature_nxt = temperature_r;
    chan7_nxt       = chan7_r;
    setpoint_nxt    = setpoint_r;
    voltage_nxt     = voltage_r;
    tx_nxt          = tx_r;
    out_valid_nxt   = pop || (out_valid_r && !out_ready);
    if (pop) begin
      case (cmd.kind)
        ACT_SPI: begin
          case (frame_r)
            FR_WAIT_HDR: begin
              tx_nxt    = velocity_r[9:2];
              frame_nxt = (cmd.byte_val == frame_header) ? FR_SETPOINT : FR_WAIT_HDR;
            end
            FR_SETPOINT: begin
              setpoint_nxt = cmd.byte_val;
              tx_nxt       = current_r;
              frame_nxt    = FR_VOLTAGE;
            end
            FR_VOLTAGE: begin
              voltage_nxt = cmd.byte_val;
              tx_nxt      = temperature_r;
              frame_nxt   = FR_PAD0;
            end
            FR_PAD0: begin
              tx_nxt    = frame_header;
              frame_nxt = FR_PAD1;
            end
            default: begin
              tx_nxt    = frame_header;
              frame_nxt = FR_WAIT_HDR;
            end
          endcase
        end
        ACT_ENC: begin
          position_nxt = cmd.step_up ? position_r + 16'd1 : position_r - 16'd1;
        end
        ACT_VEL: begin
          velocity_nxt = position_r - previous_r;
          previous_nxt = position_r;
        end
        default: begin
          if (!chan7_r) begin
            current_nxt = cmd.byte_val;
          end else begin
            temperature_nxt = cmd.byte_val;
          end
          chan7_nxt = !chan7_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r       <= FR_WAIT_HDR;
      position_r    <= '0;
      previous_r    <= '0;
      velocity_r    <= '0;
      current_r     <= '0;
      temperature_r <= '0;
      chan7_r       <= 1'b0;
      setpoint_r    <= '0;
      voltage_r     <= '0;
      tx_r          <= TX_RESET_BYTE;
      out_valid_r   <= 1'b0;
    end else begin
      frame_r       <= frame_nxt;
      position_r    <= position_nxt;
      previous_r    <= previous_nxt;
      velocity_r    <= velocity_nxt;
      current_r     <= current_nxt;
      temperature_r <= temperature_nxt;
      chan7_r       <= chan7_nxt;
      setpoint_r    <= setpoint_nxt;
      voltage_r     <= voltage_nxt;
      tx_r          <= tx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // The state registers are the result: they change only when a new item
  // is popped, which happens only when the result slot is empty or the previous result leaves.
  assign out_valid = out_valid_r;
  assign out_data  = {2'b00, frame_r, (chan7_r ? ADC_CH_SEVEN : ADC_CH_SIX),
                      velocity_r, voltage_r, setpoint_r, tx_r};

  `MNSEM_ASSERT_NXT(a_adc_toggle, pop && cmd.kind == ACT_ADC, chan7_r != $past(chan7_r))
  `MNSEM_ASSERT_NXT(a_enc_keeps_vel, pop && cmd.kind == ACT_ENC,
                    velocity_r == $past(velocity_r))
  `MNSEM_ASSERT_NXT(a_frame_close, pop && cmd.kind == ACT_SPI && frame_r == FR_PAD1,
                    frame_r == FR_WAIT_HDR && tx_r == $past(frame_header))

endmodule

`default_nettype wire

[hw/rtl/motor_node_spi_encoder_monitor.sv]
// ----------------------------------------------------------------------------
// motor_node_spi_encoder_monitor
// Motor node interface: SPI framer, quadrature position count, velocity
// latch and alternating ADC readings, with an APB header register.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake              Payload
//  in_*      in   in_tvalid/in_tready    tuser action, tdata rx/pins/sample
//  out_*     out  out_tvalid/out_tready  tdata node state report after item
//  cfg_*     in   psel/penable/pwrite    frame_header at byte address 0
//
//  One item per cycle sustained while out_tready stays high; each item passes
//  the front register, a queue slot, then the state registers that form the
//  result before out_tvalid rises for it.
//  Reset (rst_n low, synchronous) clears all state, tx byte to 0x13 and the
//  header to 0x7F. A stalled output holds the result; the queue and the front
//  register keep taking requests until both are full, then in_tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module motor_node_spi_encoder_monitor
  import mnsem_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // rx_byte [7:0], pin_levels [9:8], adc_sample [17:10], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tx_byte [7:0], speed_setpoint [15:8], voltage_command [23:16],
  // velocity [39:24], adc_channel [42:40], frame_phase [45:43], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [7:0] header_r, header_nxt;
  logic       hdr_sel;
  logic       front_valid, front_ready;
  cmd_t       front_cmd;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;

  // Config register: index from address bit 2, byte lanes ignored
  assign cfg_pready = 1'b1;
  assign hdr_sel    = (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = hdr_sel ? {24'd0, header_r} : 32'd0;

  always_comb begin
    header_nxt = header_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hdr_sel) begin
      header_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else begin
      header_r <= header_nxt;
    end
  end

  // Front: accept and classify
  mnsem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple front from back
  mnsem_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Back: advance node state and present the result
  mnsem_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_header (header_r),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata)
  );

endmodule

`default_nettype wire

[verif/motor_node_state_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_node_state_checker
// Watches the request, result and register ports of the motor node monitor.
// Keeps its own copy of the node state, works out the full state report that
// each accepted request should produce, and compares every result with it.
// ----------------------------------------------------------------------------
module motor_node_state_checker
  import mnsem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  input  wire logic                  cfg_pready,
  output int unsigned                pending_count,
  output int unsigned                mismatch_count
);

  localparam logic [2:0] PH_WAIT_HEADER = 3'd0;
  localparam logic [2:0] PH_SETPOINT    = 3'd1;
  localparam logic [2:0] PH_VOLTAGE     = 3'd2;
  localparam logic [2:0] PH_PAD_FIRST   = 3'd3;
  localparam logic [2:0] PH_PAD_SECOND  = 3'd4;

  typedef struct packed {
    logic [7:0]         tx_byte;
    logic signed [7:0]  setpoint;
    logic [7:0]         voltage;
    logic signed [15:0] velocity;
    logic [2:0]         channel;
    logic [2:0]         phase;
  } node_report_t;

  logic [7:0]  header_byte;
  logic [2:0]  framer_phase;
  logic [15:0] position;
  logic [15:0] tick_position;
  logic [15:0] velocity_counts;
  logic [7:0]  current_byte;
  logic [7:0]  temperature_byte;
  logic        on_channel_seven;
  logic [7:0]  setpoint_byte;
  logic [7:0]  voltage_byte;
  logic [7:0]  reply_byte;

  node_report_t expected_reports[$];

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Step the node copy through one request and report the state it lands in.
  function automatic node_report_t advance_node_state(action_t kind, logic [7:0] rx,
                                                       logic [1:0] pins,
                                                       logic [7:0] sample);
    node_report_t rep;
    case (kind)
      ACT_SPI: begin
        case (framer_phase)
          PH_WAIT_HEADER: begin
            reply_byte   = velocity_counts[9:2];
            framer_phase = (rx == header_byte) ? PH_SETPOINT : PH_WAIT_HEADER;
          end
          PH_SETPOINT: begin
            setpoint_byte = rx;
            reply_byte    = current_byte;
            framer_phase  = PH_VOLTAGE;
          end
          PH_VOLTAGE: begin
            voltage_byte = rx;
            reply_byte   = temperature_byte;
            framer_phase = PH_PAD_FIRST;
          end
          PH_PAD_FIRST: begin
            reply_byte   = header_byte;
            framer_phase = PH_PAD_SECOND;
          end
          default: begin
            reply_byte   = header_byte;
            framer_phase = PH_WAIT_HEADER;
          end
        endcase
      end
      ACT_ENC: begin
        // equal pin levels step up, differing levels step down
        if (pins[0] == pins[1]) position = position + 16'd1;
        else position = position - 16'd1;
      end
      ACT_VEL: begin
        velocity_counts = position - tick_position;
        tick_position   = position;
      end
      default: begin
        if (on_channel_seven) temperature_byte = sample;
        else current_byte = sample;
        on_channel_seven = !on_channel_seven;
      end
    endcase
    rep.tx_byte  = reply_byte;
    rep.setpoint = setpoint_byte;
    rep.voltage  = voltage_byte;
    rep.velocity = velocity_counts;
    rep.channel  = on_channel_seven ? ADC_CH_SEVEN : ADC_CH_SIX;
    rep.phase    = framer_phase;
    return rep;
  endfunction

  always @(posedge clk) begin : watch_ports
    node_report_t want;
    node_report_t got;
    if (!rst_n) begin
      header_byte      = HEADER_RESET;
      framer_phase     = PH_WAIT_HEADER;
      position         = '0;
      tick_position    = '0;
      velocity_counts  = '0;
      current_byte     = '0;
      temperature_byte = '0;
      on_channel_seven = 1'b0;
      setpoint_byte    = '0;
      voltage_byte     = '0;
      reply_byte       = TX_RESET_BYTE;
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.tx_byte  = out_tdata[7:0];
        got.setpoint = out_tdata[15:8];
        got.voltage  = out_tdata[23:16];
        got.velocity = out_tdata[39:24];
        got.channel  = out_tdata[42:40];
        got.phase    = out_tdata[45:43];
        if (expected_reports.size() == 0) begin
          flag_mismatch("result with no request pending", int'(got.tx_byte), 0);
        end else begin
          want = expected_reports.pop_front();
          if (got.tx_byte !== want.tx_byte)
            flag_mismatch("tx_byte", int'(got.tx_byte), int'(want.tx_byte));
          if (got.setpoint !== want.setpoint)
            flag_mismatch("speed_setpoint", int'(got.setpoint), int'(want.setpoint));
          if (got.voltage !== want.voltage)
            flag_mismatch("voltage_command", int'(got.voltage), int'(want.voltage));
          if (got.velocity !== want.velocity)
            flag_mismatch("velocity", int'(got.velocity), int'(want.velocity));
          if (got.channel !== want.channel)
            flag_mismatch("adc_channel", int'(got.channel), int'(want.channel));
          if (got.phase !== want.phase)
            flag_mismatch("frame_phase", int'(got.phase), int'(want.phase));
        end
      end
      // only the header register exists; other indexes drop the write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == '0)
        header_byte = cfg_pwdata[7:0];
      if (in_tvalid && in_tready)
        expected_reports.push_back(advance_node_state(action_t'(in_tuser), in_tdata[7:0],
                                                      in_tdata[9:8], in_tdata[17:10]));
    end
    pending_count <= expected_reports.size();
  end

endmodule

[verif/tb_motor_node_spi_encoder_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_node_spi_encoder_monitor
// Drives SPI frames, encoder edges, velocity ticks and ADC samples into the
// motor node monitor with random gaps and output stalls, under several header
// settings, and lets the state checker compare every result.
// ----------------------------------------------------------------------------
module tb_motor_node_spi_encoder_monitor;
  import mnsem_pkg::*;

  // Generous bound: every request and every result can wait out its longest random
  // gap, plus drain pauses between header settings.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int unsigned pending_count;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  logic        calm;          // no idling on either side once set
  logic [7:0]  header_now;    // header the framer currently expects

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  motor_node_spi_encoder_monitor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  motor_node_state_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  // Hold one request on the bus until it is taken, then maybe drop valid for
  // a random burst so gaps land on every phase of the node's work.
  task automatic send_request(input action_t kind, input logic [7:0] rx,
                              input logic [1:0] pins, input logic [7:0] sample);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, sample, pins, rx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Request with random content in the fields the kind does not use.
  task automatic send_spi(input logic [7:0] rx);
    send_request(ACT_SPI, rx, 2'($urandom), 8'($urandom));
  endtask

  task automatic send_other(input action_t kind, input logic [1:0] pins,
                            input logic [7:0] sample);
    send_request(kind, 8'($urandom), pins, sample);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drop valid and wait until every result is back, plus the pipe latency.
  task automatic settle_node;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_header(input logic [7:0] header);
    write_register('0, {24'($urandom), header});
    header_now = header;
  endtask

  // Mostly well-formed frames and encoder runs, with ticks, samples and noise.
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic        go_up;
    logic [1:0]  pins;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int b = 0; b < 5; b++) begin
          // frames stay in step while other kinds of request cut in
          if (b > 0 && $urandom_range(0, 5) == 0)
            send_other(action_t'($urandom_range(1, 3)), 2'($urandom), 8'($urandom));
          if (b == 0 && $urandom_range(0, 9) != 0) send_spi(header_now);
          else send_spi(8'($urandom));
        end
      end else if (pick < 65) begin
        len   = $urandom_range(1, 24);
        go_up = 1'($urandom);
        for (int e = 0; e < len; e++) begin
          pins = 2'($urandom);
          // bias the run so the count wanders far from zero
          if ($urandom_range(0, 4) != 0) begin
            if (go_up) pins[1] = pins[0];
            else pins[1] = ~pins[0];
          end
          send_other(ACT_ENC, pins, 8'($urandom));
        end
      end else if (pick < 75) begin
        send_other(ACT_VEL, 2'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        send_other(ACT_ADC, 2'($urandom), 8'($urandom));
      end else begin
        send_spi(8'($urandom));
      end
    end
  endtask

  // Result side: stall in random bursts, then run freely at the end.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if (calm) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if (!calm) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("motor_node_spi_encoder_monitor verification failed");
    $finish;
  end

  initial begin
    items_sent  = 0;
    calm        = 1'b0;
    header_now  = HEADER_RESET;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACT_SPI;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a miss, the reset header, then a full frame with extreme bytes.
    send_spi(8'h7E);
    send_spi(HEADER_RESET);
    send_spi(8'h80);
    send_spi(8'hFF);
    send_spi(8'h00);
    send_spi(8'hFF);
    // Count down through zero to wrap, then back up with both equal patterns.
    send_other(ACT_ENC, 2'b01, 8'h00);
    send_other(ACT_ENC, 2'b10, 8'hFF);
    send_other(ACT_VEL, 2'b00, 8'h00);
    send_other(ACT_ENC, 2'b00, 8'h00);
    send_other(ACT_ENC, 2'b11, 8'hFF);
    send_other(ACT_ENC, 2'b00, 8'h00);
    send_other(ACT_VEL, 2'b11, 8'hFF);
    // Readings alternate current and temperature at both sample extremes.
    send_other(ACT_ADC, 2'b00, 8'hFF);
    send_other(ACT_ADC, 2'b11, 8'h00);
    send_other(ACT_ADC, 2'b01, 8'h00);
    send_other(ACT_ADC, 2'b10, 8'hFF);
    // Second frame: most positive setpoint, zero voltage, velocity in the reply.
    send_spi(HEADER_RESET);
    send_spi(8'h7F);
    send_spi(8'h00);
    send_spi(8'h55);
    send_spi(8'hAA);
    send_spi(8'h00);
    settle_node();

    set_header(8'h00);
    run_random(PHASE_ITEMS);
    settle_node();

    set_header(8'hFF);
    run_random(PHASE_ITEMS);
    settle_node();

    set_header(8'($urandom));
    // index one holds no register; the write must leave the header alone
    write_register(CFG_ADDR_W'(4), $urandom);
    run_random(PHASE_ITEMS);
    settle_node();

    set_header(8'($urandom));
    run_random(PHASE_ITEMS / 2);
    calm = 1'b1;
    run_random(PHASE_ITEMS / 2);

    settle_node();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("motor_node_spi_encoder_monitor verification clean");
    end else begin
      $display("motor_node_spi_encoder_monitor verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mnsem_pkg.sv
hw/rtl/mnsem_front.sv
hw/rtl/mnsem_queue.sv
hw/rtl/mnsem_back.sv
hw/rtl/motor_node_spi_encoder_monitor.sv
verif/motor_node_state_checker.sv
verif/tb_motor_node_spi_encoder_monitor.sv
